>>> hdl/tmsr_pkg.sv
// Package for the text-mode scanline renderer: cell type, opcodes and the 8x8 glyph table.
// Used by the cell RAM and the top level; depends on nothing else.
package tmsr_pkg;

    // One character cell as it is kept in the cell RAM.
    typedef struct packed {
        logic [7:0] code;
        logic [7:0] colour;
    } t_cell;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_RENDER = 2'd2;

    localparam logic [7:0] C_SPACE_CODE  = 8'd32;
    localparam int         C_GLYPH_LINES = 8;

    // Whole glyph of a character, font line 0 in the low byte.
    function automatic logic [63:0] glyph_bits(input logic [6:0] code);
        logic [63:0] g;
        unique case (code)
            7'd33:   g = 64'h0018_0018_183C_3C18;
            7'd34:   g = 64'h0000_0000_0000_3636;
            7'd35:   g = 64'h0036_367F_367F_3636;
            7'd36:   g = 64'h000C_1F30_1E03_3E0C;
            7'd37:   g = 64'h0063_660C_1833_6300;
            7'd38:   g = 64'h006E_333B_6E1C_361C;
            7'd39:   g = 64'h0000_0000_0003_0606;
            7'd40:   g = 64'h0018_0C06_0606_0C18;
            7'd41:   g = 64'h0006_0C18_1818_0C06;
            7'd42:   g = 64'h0000_663C_FF3C_6600;
            7'd43:   g = 64'h0000_0C0C_3F0C_0C00;
            7'd44:   g = 64'h060C_0C00_0000_0000;
            7'd45:   g = 64'h0000_0000_3F00_0000;
            7'd46:   g = 64'h000C_0C00_0000_0000;
            7'd47:   g = 64'h0001_0306_0C18_3060;
            7'd48:   g = 64'h003E_676F_7B73_633E;
            7'd49:   g = 64'h003F_0C0C_0C0C_0E0C;
            7'd50:   g = 64'h003F_3306_1C30_331E;
            7'd51:   g = 64'h001E_3330_1C30_331E;
            7'd52:   g = 64'h0078_307F_3336_3C38;
            7'd53:   g = 64'h001E_3330_301F_033F;
            7'd54:   g = 64'h001E_3333_1F03_061C;
            7'd55:   g = 64'h000C_0C0C_1830_333F;
            7'd56:   g = 64'h001E_3333_1E33_331E;
            7'd57:   g = 64'h000E_1830_3E33_331E;
            7'd58:   g = 64'h000C_0C00_000C_0C00;
            7'd59:   g = 64'h060C_0C00_000C_0C00;
            7'd60:   g = 64'h0018_0C06_0306_0C18;
            7'd61:   g = 64'h0000_3F00_003F_0000;
            7'd62:   g = 64'h0006_0C18_3018_0C06;
            7'd63:   g = 64'h000C_000C_1830_331E;
            7'd64:   g = 64'h001E_037B_7B7B_633E;
            7'd65:   g = 64'h0033_333F_3333_1E0C;
            7'd66:   g = 64'h003F_6666_3E66_663F;
            7'd67:   g = 64'h003C_6603_0303_663C;
            7'd68:   g = 64'h001F_3666_6666_361F;
            7'd69:   g = 64'h007F_4616_1E16_467F;
            7'd70:   g = 64'h000F_0616_1E16_467F;
            7'd71:   g = 64'h007C_6673_0303_663C;
            7'd72:   g = 64'h0033_3333_3F33_3333;
            7'd73:   g = 64'h001E_0C0C_0C0C_0C1E;
            7'd74:   g = 64'h001E_3333_3030_3078;
            7'd75:   g = 64'h0067_6636_1E36_6667;
            7'd76:   g = 64'h007F_6646_0606_060F;
            7'd77:   g = 64'h0063_636B_7F7F_7763;
            7'd78:   g = 64'h0063_6373_7B6F_6763;
            7'd79:   g = 64'h001C_3663_6363_361C;
            7'd80:   g = 64'h000F_0606_3E66_663F;
            7'd81:   g = 64'h0038_1E3B_3333_331E;
            7'd82:   g = 64'h0067_6636_3E66_663F;
            7'd83:   g = 64'h001E_3338_0E07_331E;
            7'd84:   g = 64'h001E_0C0C_0C0C_2D3F;
            7'd85:   g = 64'h003F_3333_3333_3333;
            7'd86:   g = 64'h000C_1E33_3333_3333;
            7'd87:   g = 64'h0063_777F_6B63_6363;
            7'd88:   g = 64'h0063_361C_1C36_6363;
            7'd89:   g = 64'h001E_0C0C_1E33_3333;
            7'd90:   g = 64'h007F_664C_1831_637F;
            7'd91:   g = 64'h001E_0606_0606_061E;
            7'd92:   g = 64'h0040_6030_180C_0603;
            7'd93:   g = 64'h001E_1818_1818_181E;
            7'd94:   g = 64'h0000_0000_6336_1C08;
            7'd95:   g = 64'hFF00_0000_0000_0000;
            7'd96:   g = 64'h0000_0000_0018_0C0C;
            7'd97:   g = 64'h006E_333E_301E_0000;
            7'd98:   g = 64'h003B_6666_3E06_0607;
            7'd99:   g = 64'h001E_3303_331E_0000;
            7'd100:  g = 64'h006E_3333_3E30_3038;
            7'd101:  g = 64'h001E_033F_331E_0000;
            7'd102:  g = 64'h000F_0606_0F06_361C;
            7'd103:  g = 64'h1F30_3E33_336E_0000;
            7'd104:  g = 64'h0067_6666_6E36_0607;
            7'd105:  g = 64'h001E_0C0C_0C0E_000C;
            7'd106:  g = 64'h1E33_3330_3030_0030;
            7'd107:  g = 64'h0067_361E_3666_0607;
            7'd108:  g = 64'h001E_0C0C_0C0C_0C0E;
            7'd109:  g = 64'h0063_6B7F_7F33_0000;
            7'd110:  g = 64'h0033_3333_331F_0000;
            7'd111:  g = 64'h001E_3333_331E_0000;
            7'd112:  g = 64'h0F06_3E66_663B_0000;
            7'd113:  g = 64'h7830_3E33_336E_0000;
            7'd114:  g = 64'h000F_0666_6E3B_0000;
            7'd115:  g = 64'h001F_301E_033E_0000;
            7'd116:  g = 64'h0018_2C0C_0C3E_0C08;
            7'd117:  g = 64'h006E_3333_3333_0000;
            7'd118:  g = 64'h000C_1E33_3333_0000;
            7'd119:  g = 64'h0036_7F7F_6B63_0000;
            7'd120:  g = 64'h0063_361C_3663_0000;
            7'd121:  g = 64'h1F30_3E33_3333_0000;
            7'd122:  g = 64'h003F_260C_193F_0000;
            7'd123:  g = 64'h0038_0C0C_070C_0C38;
            7'd124:  g = 64'h0018_1818_0018_1818;
            7'd125:  g = 64'h0007_0C0C_380C_0C07;
            7'd126:  g = 64'h0000_0000_0000_3B6E;
            default: g = 64'h0;
        endcase
        return g;
    endfunction

    // One font line of a character; bit 0 is the leftmost pixel.
    function automatic logic [7:0] glyph_line(input logic [6:0] code, input logic [2:0] sub);
        logic [63:0] g;
        g = glyph_bits(code);
        return g[{sub, 3'b000} +: 8];
    endfunction

endpackage

>>> hdl/tmsr_cmd_if.sv
// Command channel of the text-mode scanline renderer: valid/ready plus one command.
// Self-contained; no package needed.
interface tmsr_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] cell_column;
    logic [7:0] cell_row;
    logic [7:0] char_code;
    logic [7:0] cell_colour;
    logic [7:0] run_length;
    logic [9:0] scan_line;

    modport source (
        output valid, opcode, cell_column, cell_row, char_code, cell_colour,
               run_length, scan_line,
        input  ready
    );
    modport sink (
        input  valid, opcode, cell_column, cell_row, char_code, cell_colour,
               run_length, scan_line,
        output ready
    );
endinterface

>>> hdl/tmsr_pix_if.sv
// Pixel channel of the text-mode scanline renderer: valid/ready plus eight pixel colours.
// Self-contained; no package needed.
interface tmsr_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_0;
    logic [7:0] pixel_1;
    logic [7:0] pixel_2;
    logic [7:0] pixel_3;
    logic [7:0] pixel_4;
    logic [7:0] pixel_5;
    logic [7:0] pixel_6;
    logic [7:0] pixel_7;

    modport source (
        output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6,
               pixel_7,
        input  ready
    );
    modport sink (
        input  valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6,
               pixel_7,
        output ready
    );
endinterface

>>> hdl/tmsr_cell_ram.sv
// Character cell RAM: one write port and one registered read port on a shared address.
// Depends on tmsr_pkg for the cell type.
module tmsr_cell_ram #(
    parameter int DEPTH  = 4800,
    parameter int ADDR_W = 13
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic                 i_re,
    input  logic [ADDR_W-1:0]    i_addr,
    input  tmsr_pkg::t_cell      i_wdata,
    output tmsr_pkg::t_cell      o_rdata
);
    import tmsr_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/text_mode_scanline_renderer_top.sv
// Top level of the text-mode scanline renderer: command sequencer, shared address adder,
// glyph lookup and pixel output register. Depends on tmsr_pkg, tmsr_cmd_if, tmsr_pix_if
// and tmsr_cell_ram.
//
//   Channel  | Direction | Carries
//   ---------+-----------+----------------------------------------------------------
//   i_cmd    | in        | opcode, cell_column, cell_row, char_code, cell_colour,
//            |           | run_length, scan_line
//   o_pix    | out       | pixel_0 .. pixel_7, one transfer per render command
//
// After reset the block sweeps the whole cell RAM to zero, one cell per cycle, over all
// TEXT_COLUMNS * TEXT_ROWS_COUNT cells (4800 at the defaults); i_cmd.ready stays low.
// A cell write passes through S_ADDR and S_WRITE, a clear through S_ADDR and then S_CLEAR
// once per cleared cell, and a render through S_ADDR, S_READ, S_GLYPH and S_OUT, where
// it waits out any stall on o_pix; a render outside the grid goes from the accepting
// state straight to S_OUT. An ignored command leaves the sequencer in S_IDLE.
// The steps follow from the shared cell RAM address and the one address adder. A new
// command is taken only while the sequencer is idle.
module text_mode_scanline_renderer_top #(
    parameter int TEXT_COLUMNS    = 80,
    parameter int TEXT_ROWS_COUNT = 60
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmsr_cmd_if.sink   i_cmd,
    tmsr_pix_if.source o_pix
);
    import tmsr_pkg::*;

    localparam int CELLS  = TEXT_COLUMNS * TEXT_ROWS_COUNT;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_W  = (TEXT_ROWS_COUNT > 1) ? $clog2(TEXT_ROWS_COUNT) : 1;

    // Sequencer states.
    localparam logic [2:0] S_INIT  = 3'd0;  // clearing sweep after reset
    localparam logic [2:0] S_IDLE  = 3'd1;  // ready for a command
    localparam logic [2:0] S_ADDR  = 3'd2;  // cell address = row base + column
    localparam logic [2:0] S_WRITE = 3'd3;  // single cell write
    localparam logic [2:0] S_CLEAR = 3'd4;  // one cleared cell per cycle
    localparam logic [2:0] S_READ  = 3'd5;  // cell RAM read
    localparam logic [2:0] S_GLYPH = 3'd6;  // font line lookup
    localparam logic [2:0] S_OUT   = 3'd7;  // pixels wait for the output transfer

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [7:0]        r_col, n_col;
    logic [7:0]        r_len, n_len;
    logic [2:0]        r_sub, n_sub;
    t_cell             r_cell, n_cell;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [7:0]        r_bits, n_bits;

    logic              cmd_accept;
    logic [7:0]        row_sel;
    logic              row_ok;
    logic              col_ok;
    logic              clear_last;

    // The one shared adder: row base plus column, or address plus one.
    logic [ADDR_W-1:0] add_a;
    logic [ADDR_W-1:0] add_b;
    logic [ADDR_W-1:0] add_sum;

    logic              ram_we;
    logic              ram_re;
    t_cell             ram_wdata;
    t_cell             ram_rdata;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;

    // A render takes its text row from the scan line; writes and clears name it directly.
    assign row_sel = (i_cmd.opcode == OP_RENDER) ? {1'b0, i_cmd.scan_line[9:3]}
                                                 : i_cmd.cell_row;
    assign row_ok  = row_sel < 8'(TEXT_ROWS_COUNT);
    assign col_ok  = i_cmd.cell_column < 8'(TEXT_COLUMNS);

    assign clear_last = (r_len == 8'd1) || (r_col == 8'(TEXT_COLUMNS - 1));

    assign add_a   = (r_state == S_ADDR) ? r_base : r_addr;
    assign add_b   = (r_state == S_ADDR) ? ADDR_W'(r_col) : ADDR_W'(1);
    assign add_sum = add_a + add_b;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_col   = r_col;
        n_len   = r_len;
        n_sub   = r_sub;
        n_cell  = r_cell;
        n_base  = r_base;
        n_addr  = r_addr;
        n_bits  = r_bits;

        unique case (r_state)
            S_INIT: begin
                n_addr = add_sum;
                if (r_addr == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_accept) begin
                    n_op        = i_cmd.opcode;
                    n_col       = i_cmd.cell_column;
                    n_len       = i_cmd.run_length;
                    n_sub       = i_cmd.scan_line[2:0];
                    n_cell.code   = i_cmd.char_code;
                    n_cell.colour = i_cmd.cell_colour;
                    n_base      = ADDR_W'(row_sel[ROW_W-1:0]) * ADDR_W'(TEXT_COLUMNS);
                    n_bits      = '0;
                    case (i_cmd.opcode)
                        OP_WRITE: begin
                            if (row_ok && col_ok && (i_cmd.char_code != 8'd0)) begin
                                n_state = S_ADDR;
                            end
                        end
                        OP_CLEAR: begin
                            if (row_ok && col_ok && (i_cmd.run_length != 8'd0)) begin
                                n_state = S_ADDR;
                            end
                        end
                        OP_RENDER: begin
                            // Outside the grid the pixels are all blank right away.
                            n_state = (row_ok && col_ok) ? S_ADDR : S_OUT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADDR: begin
                n_addr = add_sum;
                case (r_op)
                    OP_WRITE: n_state = S_WRITE;
                    OP_CLEAR: n_state = S_CLEAR;
                    default:  n_state = S_READ;
                endcase
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            S_CLEAR: begin
                n_addr = add_sum;
                n_col  = r_col + 8'd1;
                n_len  = r_len - 8'd1;
                if (clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_GLYPH;
            end
            S_GLYPH: begin
                // Empty cells, colour zero and codes above 127 render blank.
                n_cell.colour = ram_rdata.colour;
                if ((ram_rdata.code == 8'd0) || (ram_rdata.colour == 8'd0)
                        || ram_rdata.code[7]) begin
                    n_bits = '0;
                end else begin
                    n_bits = glyph_line(ram_rdata.code[6:0], r_sub);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_pix.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_col  <= n_col;
        r_len  <= n_len;
        r_sub  <= n_sub;
        r_cell <= n_cell;
        r_base <= n_base;
        r_bits <= n_bits;
    end

    // Cell RAM: the sweep writes zero, a clear writes a space with colour zero.
    assign ram_we = (r_state == S_INIT) || (r_state == S_WRITE) || (r_state == S_CLEAR);
    assign ram_re = (r_state == S_READ);

    always_comb begin
        if (r_state == S_WRITE) begin
            ram_wdata = r_cell;
        end else if (r_state == S_CLEAR) begin
            ram_wdata.code   = C_SPACE_CODE;
            ram_wdata.colour = 8'd0;
        end else begin
            ram_wdata = '0;
        end
    end

    tmsr_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (r_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // A lit pixel shows the cell colour, an unlit one is zero.
    assign o_pix.valid   = (r_state == S_OUT);
    assign o_pix.pixel_0 = r_bits[0] ? r_cell.colour : 8'd0;
    assign o_pix.pixel_1 = r_bits[1] ? r_cell.colour : 8'd0;
    assign o_pix.pixel_2 = r_bits[2] ? r_cell.colour : 8'd0;
    assign o_pix.pixel_3 = r_bits[3] ? r_cell.colour : 8'd0;
    assign o_pix.pixel_4 = r_bits[4] ? r_cell.colour : 8'd0;
    assign o_pix.pixel_5 = r_bits[5] ? r_cell.colour : 8'd0;
    assign o_pix.pixel_6 = r_bits[6] ? r_cell.colour : 8'd0;
    assign o_pix.pixel_7 = r_bits[7] ? r_cell.colour : 8'd0;

`ifndef ASSERT_OFF
    // No command may enter while the reset sweep still owns the cell RAM.
    a_no_cmd_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !i_cmd.ready)
        else $error("command port ready during reset sweep");

    // A clear never walks past the last cell of the grid.
    a_clear_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (r_addr <= ADDR_W'(CELLS - 1)))
        else $error("clear address beyond grid");

    // Pixels are never offered while the cell RAM is being written.
    a_no_write_with_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> !ram_we)
        else $error("cell write while pixels pending");

    // Each render gives one pixel transfer and the block then returns to idle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.ready) |=> (!o_pix.valid && i_cmd.ready))
        else $error("pixel transfer not followed by idle");
`endif

endmodule

>>> tb/sv/tmsr_tb_pkg.sv
`timescale 1ns / 100ps
// Verification package for the text-mode scanline renderer: command record, glyph table and
// the pixel scoreboard that predicts every render from its own copy of the character grid.
// Depends on tmsr_pkg for the opcode names.
package tmsr_tb_pkg;

    import tmsr_pkg::*;

    localparam int GRID_COLUMNS = 80;
    localparam int GRID_ROWS    = 60;
    localparam int GRID_CELLS   = GRID_COLUMNS * GRID_ROWS;

    // The fourth opcode value has no meaning for the block.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] cell_column;
        logic [7:0] cell_row;
        logic [7:0] char_code;
        logic [7:0] cell_colour;
        logic [7:0] run_length;
        logic [9:0] scan_line;
    } tmsr_cmd_t;

    // Element k is the colour of pixel k, leftmost first.
    typedef logic [7:0][7:0] pixel_octet_t;

    // Glyphs for codes 32 to 127, font line 0 in the most significant byte.
    localparam logic [63:0] GLYPH_TABLE [0:95] = '{
        64'h00000000_00000000, 64'h183C3C18_18001800, 64'h36360000_00000000,
        64'h36367F36_7F363600, 64'h0C3E031E_301F0C00, 64'h00633318_0C666300,
        64'h1C361C6E_3B336E00, 64'h06060300_00000000, 64'h180C0606_060C1800,
        64'h060C1818_180C0600, 64'h00663CFF_3C660000, 64'h000C0C3F_0C0C0000,
        64'h00000000_000C0C06, 64'h0000003F_00000000, 64'h00000000_000C0C00,
        64'h6030180C_06030100, 64'h3E63737B_6F673E00, 64'h0C0E0C0C_0C0C3F00,
        64'h1E33301C_06333F00, 64'h1E33301C_30331E00, 64'h383C3633_7F307800,
        64'h3F031F30_30331E00, 64'h1C06031F_33331E00, 64'h3F333018_0C0C0C00,
        64'h1E33331E_33331E00, 64'h1E33333E_30180E00, 64'h000C0C00_000C0C00,
        64'h000C0C00_000C0C06, 64'h180C0603_060C1800, 64'h00003F00_003F0000,
        64'h060C1830_180C0600, 64'h1E333018_0C000C00, 64'h3E637B7B_7B031E00,
        64'h0C1E3333_3F333300, 64'h3F66663E_66663F00, 64'h3C660303_03663C00,
        64'h1F366666_66361F00, 64'h7F46161E_16467F00, 64'h7F46161E_16060F00,
        64'h3C660303_73667C00, 64'h3333333F_33333300, 64'h1E0C0C0C_0C0C1E00,
        64'h78303030_33331E00, 64'h6766361E_36666700, 64'h0F060606_46667F00,
        64'h63777F7F_6B636300, 64'h63676F7B_73636300, 64'h1C366363_63361C00,
        64'h3F66663E_06060F00, 64'h1E333333_3B1E3800, 64'h3F66663E_36666700,
        64'h1E33070E_38331E00, 64'h3F2D0C0C_0C0C1E00, 64'h33333333_33333F00,
        64'h33333333_331E0C00, 64'h6363636B_7F776300, 64'h6363361C_1C366300,
        64'h3333331E_0C0C1E00, 64'h7F633118_4C667F00, 64'h1E060606_06061E00,
        64'h03060C18_30604000, 64'h1E181818_18181E00, 64'h081C3663_00000000,
        64'h00000000_000000FF, 64'h0C0C1800_00000000, 64'h00001E30_3E336E00,
        64'h0706063E_66663B00, 64'h00001E33_03331E00, 64'h3830303E_33336E00,
        64'h00001E33_3F031E00, 64'h1C36060F_06060F00, 64'h00006E33_333E301F,
        64'h0706366E_66666700, 64'h0C000E0C_0C0C1E00, 64'h30003030_3033331E,
        64'h07066636_1E366700, 64'h0E0C0C0C_0C0C1E00, 64'h0000337F_7F6B6300,
        64'h00001F33_33333300, 64'h00001E33_33331E00, 64'h00003B66_663E060F,
        64'h00006E33_333E3078, 64'h00003B6E_66060F00, 64'h00003E03_1E301F00,
        64'h080C3E0C_0C2C1800, 64'h00003333_33336E00, 64'h00003333_331E0C00,
        64'h0000636B_7F7F3600, 64'h00006336_1C366300, 64'h00003333_333E301F,
        64'h00003F19_0C263F00, 64'h380C0C07_0C0C3800, 64'h18181800_18181800,
        64'h070C0C38_0C0C0700, 64'h6E3B0000_00000000, 64'h00000000_00000000
    };

    class glyph_scoreboard;

        logic [7:0]   cell_codes   [GRID_CELLS];
        logic [7:0]   cell_colours [GRID_CELLS];
        pixel_octet_t expected_octets [$];
        int           failures;
        int           checked;

        function new();
            foreach (cell_codes[i]) begin
                cell_codes[i]   = '0;
                cell_colours[i] = '0;
            end
            failures = 0;
            checked  = 0;
        endfunction

        function pixel_octet_t render_octet(input logic [7:0] col, input logic [9:0] line);
            pixel_octet_t px;
            logic [63:0]  glyph;
            logic [7:0]   code;
            logic [7:0]   colour;
            logic [7:0]   bits;
            int           row;
            int           sub;
            int           idx;
            px  = '0;
            row = int'(line[9:3]);
            sub = int'(line[2:0]);
            if (row >= GRID_ROWS || int'(col) >= GRID_COLUMNS) return px;
            idx    = row * GRID_COLUMNS + int'(col);
            code   = cell_codes[idx];
            colour = cell_colours[idx];
            if (code == 8'd0 || colour == 8'd0 || code > 8'd127 || code < 8'd32) return px;
            glyph = GLYPH_TABLE[int'(code) - 32];
            bits  = glyph[63 - 8 * sub -: 8];
            for (int k = 0; k < 8; k++) begin
                if (bits[k]) px[k] = colour;
            end
            return px;
        endfunction

        // Called once per accepted command, in order of acceptance.
        function void note_command(input tmsr_cmd_t c);
            int col;
            int row;
            int base;
            col = int'(c.cell_column);
            row = int'(c.cell_row);
            case (c.opcode)
                OP_WRITE: begin
                    if (c.char_code != 8'd0 && col < GRID_COLUMNS && row < GRID_ROWS) begin
                        cell_codes[row * GRID_COLUMNS + col]   = c.char_code;
                        cell_colours[row * GRID_COLUMNS + col] = c.cell_colour;
                    end
                end
                OP_CLEAR: begin
                    if (row < GRID_ROWS) begin
                        base = row * GRID_COLUMNS;
                        for (int k = 0; k < int'(c.run_length) && col + k < GRID_COLUMNS;
                             k++) begin
                            cell_codes[base + col + k]   = C_SPACE_CODE;
                            cell_colours[base + col + k] = 8'd0;
                        end
                    end
                end
                OP_RENDER: expected_octets.push_back(render_octet(c.cell_column, c.scan_line));
                default: ;
            endcase
        endfunction

        function void check_pixels(input pixel_octet_t got);
            pixel_octet_t want;
            if (expected_octets.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pixel transfer %h after %0d results", got, checked);
                return;
            end
            want = expected_octets.pop_front();
            for (int k = 0; k < 8; k++) begin
                if (got[k] !== want[k]) begin
                    failures++;
                    if (failures <= 10)
                        $display("result %0d pixel_%0d: expected %02h, got %02h",
                                 checked, k, want[k], got[k]);
                end
            end
            checked++;
        endfunction

        function int pending();
            return expected_octets.size();
        endfunction

    endclass

endpackage

>>> tb/sv/text_mode_scanline_renderer_top_test.sv
`timescale 1ns / 100ps
// Top-level test of the text-mode scanline renderer: directed and random commands on i_cmd,
// render results checked on o_pix against the scoreboard in tmsr_tb_pkg.
// Depends on tmsr_pkg, tmsr_tb_pkg, tmsr_cmd_if, tmsr_pix_if and the renderer RTL.
module text_mode_scanline_renderer_top_test;

    import tmsr_pkg::*;
    import tmsr_tb_pkg::*;

    // Commands that change the grid or produce pixels; ignored ones are not counted.
    localparam int RANDOM_COMMANDS = 1800;
    // Generous watchdog: it covers the reset sweep over all 4800 cells and the slowest command
    // (a full-row clear behind a long sender gap and a long receiver stall).
    localparam int CYCLE_LIMIT     = 1_000_000;
    // Slowest command is a clear of 80 cells; wait comfortably past it.
    localparam int TAIL_CYCLES     = 200;
    // One long hold-off on o_pix after this many results, so the block backs up i_cmd.
    localparam int HOLD_AFTER      = 120;
    localparam int HOLD_CYCLES     = 400;

    logic clk = 1'b0;
    logic rst_n;

    tmsr_cmd_if cmd_ch ();
    tmsr_pix_if pix_ch ();

    glyph_scoreboard sb = new();

    int commands_sent = 0;

    text_mode_scanline_renderer_top #(
        .TEXT_COLUMNS   (GRID_COLUMNS),
        .TEXT_ROWS_COUNT(GRID_ROWS)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_ch),
        .o_pix  (pix_ch)
    );

    always #5 clk = ~clk;

    // Every block input is known from time zero.
    initial begin
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.opcode      = OP_WRITE;
        cmd_ch.cell_column = '0;
        cmd_ch.cell_row    = '0;
        cmd_ch.char_code   = '0;
        cmd_ch.cell_colour = '0;
        cmd_ch.run_length  = '0;
        cmd_ch.scan_line   = '0;
        pix_ch.ready       = 1'b0;
    end

    // Watchdog. Anything still running here has hung or lost a transfer.
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Sender gaps: mostly back-to-back or short, now and then a long one. Every fourth block
    // of 100 commands goes with no gaps at all so the block also sees a saturated input.
    function automatic int pick_gap();
        int r;
        if ((commands_sent / 100) % 4 == 3) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic tmsr_cmd_t make_cmd(input logic [1:0] op, input int col, input int row,
                                           input int code, input int colour, input int len,
                                           input int line);
        tmsr_cmd_t c;
        c.opcode      = op;
        c.cell_column = 8'(col);
        c.cell_row    = 8'(row);
        c.char_code   = 8'(code);
        c.cell_colour = 8'(colour);
        c.run_length  = 8'(len);
        c.scan_line   = 10'(line);
        return c;
    endfunction

    // Mostly well-formed traffic aimed at a small window of cells, so that renders land on
    // cells that were written or cleared recently. About one command in ten is noise: every field
    // but the column and row takes any value, the unused opcode included.
    function automatic tmsr_cmd_t random_command();
        tmsr_cmd_t c;
        int        r;
        int        row;
        bit        hot;
        c   = tmsr_cmd_t'({$urandom(), $urandom()});
        r   = $urandom_range(0, 99);
        hot = ($urandom_range(0, 9) < 7);
        c.cell_column = hot ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, GRID_COLUMNS - 1));
        row           = hot ? $urandom_range(0, 3) : $urandom_range(0, GRID_ROWS - 1);
        c.cell_row    = 8'(row);
        if (r < 30) begin
            c.opcode = OP_WRITE;
            case ($urandom_range(0, 19))
                0, 1:    c.char_code = 8'($urandom_range(128, 255));
                2:       c.char_code = ($urandom_range(0, 1) != 0) ? C_SPACE_CODE : 8'd127;
                default: c.char_code = 8'($urandom_range(33, 126));
            endcase
            c.cell_colour = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        end else if (r < 40) begin
            c.opcode = OP_CLEAR;
            case ($urandom_range(0, 19))
                0:       c.run_length = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(81, 255));
                1, 2, 3: c.run_length = 8'($urandom_range(9, 80));
                default: c.run_length = 8'($urandom_range(1, 8));
            endcase
        end else if (r < 90) begin
            c.opcode = OP_RENDER;
            if ($urandom_range(0, 19) == 0)
                c.scan_line = 10'($urandom_range(GRID_ROWS * 8, 1023));
            else
                c.scan_line = 10'(row * 8 + $urandom_range(0, 7));
        end else begin
            c.opcode = 2'($urandom_range(0, 3));
        end
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer. With no gap
    // the valid stays high and only the payload changes, so valid never toggles in one step.
    task automatic send_command(input tmsr_cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.opcode      = c.opcode;
        cmd_ch.cell_column = c.cell_column;
        cmd_ch.cell_row    = c.cell_row;
        cmd_ch.char_code   = c.char_code;
        cmd_ch.cell_colour = c.cell_colour;
        cmd_ch.run_length  = c.run_length;
        cmd_ch.scan_line   = c.scan_line;
        cmd_ch.valid       = 1'b1;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        sb.note_command(c);
        commands_sent++;
        @(negedge clk);
    endtask

    // Receiver side. The ready pattern switches at random between always ready, randomly ready
    // and stall-prone modes. Once, early on, it holds off for a long stretch while the sender
    // keeps offering, which backs the block up into i_cmd.
    initial begin
        int  stall_left;
        int  mode_left;
        int  ready_mode;
        bit  held_off;
        stall_left = 0;
        mode_left  = 0;
        ready_mode = 0;
        held_off   = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                pix_ch.ready = 1'b0;
            end else if (!held_off && sb.checked >= HOLD_AFTER) begin
                held_off     = 1'b1;
                stall_left   = HOLD_CYCLES;
                pix_ch.ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(50, 300);
                end else begin
                    mode_left--;
                end
                case (ready_mode)
                    0: pix_ch.ready = 1'b1;
                    1: pix_ch.ready = ($urandom_range(0, 3) != 0);
                    default: begin
                        if ($urandom_range(0, 19) == 0) begin
                            stall_left   = $urandom_range(8, 40);
                            pix_ch.ready = 1'b0;
                        end else begin
                            pix_ch.ready = ($urandom_range(0, 1) != 0);
                        end
                    end
                endcase
            end
        end
    end

    // Results are sampled at the rising edge, before the block's own updates land.
    always @(posedge clk) begin
        pixel_octet_t got;
        if (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
            got[0] = pix_ch.pixel_0;
            got[1] = pix_ch.pixel_1;
            got[2] = pix_ch.pixel_2;
            got[3] = pix_ch.pixel_3;
            got[4] = pix_ch.pixel_4;
            got[5] = pix_ch.pixel_5;
            got[6] = pix_ch.pixel_6;
            got[7] = pix_ch.pixel_7;
            sb.check_pixels(got);
        end
    end

    initial begin
        tmsr_cmd_t c;
        int        counted;
        bit        takes_effect;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The block's reset sweep keeps i_cmd.ready low for a while; the first
        // transfer simply waits for it.
        // A fresh grid renders blank.
        send_command(make_cmd(OP_RENDER, 0, 0, 0, 0, 0, 0));
        // Capital A in full colour at the top-left cell, then its second font line.
        send_command(make_cmd(OP_WRITE, 0, 0, 65, 8'hFF, 0, 0));
        send_command(make_cmd(OP_RENDER, 0, 0, 0, 0, 0, 1));
        // Character zero stores nothing.
        send_command(make_cmd(OP_WRITE, 1, 0, 0, 7, 0, 0));
        send_command(make_cmd(OP_RENDER, 1, 0, 0, 0, 0, 0));
        // Codes above 127 are stored but render blank; bottom-right cell of the grid.
        send_command(make_cmd(OP_WRITE, GRID_COLUMNS - 1, GRID_ROWS - 1, 255, 8'h5A, 0, 0));
        send_command(make_cmd(OP_RENDER, GRID_COLUMNS - 1, 0, 0, 0, 0, GRID_ROWS * 8 - 5));
        // Writes past the last column, past the last row, and at the far corner of the range.
        send_command(make_cmd(OP_WRITE, GRID_COLUMNS, 0, 66, 3, 0, 0));
        send_command(make_cmd(OP_WRITE, 0, GRID_ROWS, 67, 3, 0, 0));
        send_command(make_cmd(OP_WRITE, 255, 255, 68, 8'hFF, 255, 1023));
        // Two cells at the row end, then a clear that runs off the row and is clipped.
        send_command(make_cmd(OP_WRITE, GRID_COLUMNS - 2, 0, 35, 8'h81, 0, 0));
        send_command(make_cmd(OP_WRITE, GRID_COLUMNS - 1, 0, 127, 8'h42, 0, 0));
        send_command(make_cmd(OP_RENDER, GRID_COLUMNS - 2, 0, 0, 0, 0, 2));
        send_command(make_cmd(OP_CLEAR, GRID_COLUMNS - 2, 0, 0, 0, 255, 0));
        send_command(make_cmd(OP_RENDER, GRID_COLUMNS - 2, 0, 0, 0, 0, 2));
        // Underscore with colour zero is blank; with a colour its last line is fully lit.
        send_command(make_cmd(OP_WRITE, 2, 1, 95, 0, 0, 0));
        send_command(make_cmd(OP_RENDER, 2, 0, 0, 0, 0, 15));
        send_command(make_cmd(OP_WRITE, 3, 1, 95, 8'hC3, 0, 0));
        // A zero-length clear changes nothing, so the lit underscore line still renders.
        send_command(make_cmd(OP_CLEAR, 3, 1, 0, 0, 0, 0));
        send_command(make_cmd(OP_RENDER, 3, 0, 0, 0, 0, 15));
        // Clears below the grid or starting past the row end do nothing.
        send_command(make_cmd(OP_CLEAR, 0, GRID_ROWS, 0, 0, 5, 0));
        send_command(make_cmd(OP_CLEAR, 200, 0, 0, 0, 10, 0));
        // Renders of the first line below the grid, the last possible line and a column past it.
        send_command(make_cmd(OP_RENDER, 0, 0, 0, 0, 0, GRID_ROWS * 8));
        send_command(make_cmd(OP_RENDER, 255, 255, 255, 255, 255, 1023));
        send_command(make_cmd(OP_RENDER, GRID_COLUMNS, 0, 0, 0, 0, 0));
        // The unused opcode does nothing at all.
        send_command(make_cmd(OP_UNUSED, 0, 0, 255, 255, 255, 1023));

        // Random part, counted by commands that do something.
        counted = 0;
        while (counted < RANDOM_COMMANDS) begin
            c = random_command();
            takes_effect = (c.opcode == OP_RENDER)
                || (c.opcode == OP_WRITE && c.char_code != 8'd0
                    && int'(c.cell_column) < GRID_COLUMNS && int'(c.cell_row) < GRID_ROWS)
                || (c.opcode == OP_CLEAR && c.run_length != 8'd0
                    && int'(c.cell_column) < GRID_COLUMNS && int'(c.cell_row) < GRID_ROWS);
            send_command(c);
            if (takes_effect) counted++;
        end
        cmd_ch.valid = 1'b0;

        // Drain, then give the block time to show any stray transfer.
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/tmsr_pkg.sv
hdl/tmsr_cmd_if.sv
hdl/tmsr_pix_if.sv
hdl/tmsr_cell_ram.sv
hdl/text_mode_scanline_renderer_top.sv
tb/sv/tmsr_tb_pkg.sv
tb/sv/text_mode_scanline_renderer_top_test.sv
